@@ src/bsl_pkg.sv @@
// Package for the bounded sequence list engine: sizes, operation and status
// codes, cell commands and the transaction structs. No dependencies.
package bsl_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_DEL_VAL = 3'd2,
    OP_DEL_POS = 3'd3,
    OP_REVERSE = 3'd4,
    OP_READOUT = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_INSERT,
    CELL_DEL_VAL,
    CELL_DEL_POS,
    CELL_REVERSE,
    CELL_ROTATE
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    cell_cmd_t                cmd;
    logic [CNT_W-1:0]         count;
    logic [VALUE_WIDTH-1:0]   value;
    logic [7:0]               position;
  } cell_ctl_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] item_value;
    logic [7:0]         position;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    status_t            status;
    logic [4:0]         entry_count;
    logic               last;
  } out_item_t;

endpackage

@@ src/bsl_cell.sv @@
// One storage cell of the list chain: holds one entry and takes its next
// value from itself, a neighbor, the head, its mirror or the new value.
// Depends on bsl_pkg.
module bsl_cell (
  input  logic                            clk,
  input  logic [bsl_pkg::IDX_W-1:0]       idx,
  input  bsl_pkg::cell_ctl_t              ctl,
  input  logic [bsl_pkg::VALUE_WIDTH-1:0] left_value,
  input  logic [bsl_pkg::VALUE_WIDTH-1:0] right_value,
  input  logic [bsl_pkg::VALUE_WIDTH-1:0] head_value,
  input  logic [bsl_pkg::VALUE_WIDTH-1:0] mirror_value,
  input  logic                            hit_in,
  output logic                            hit_out,
  output logic [bsl_pkg::VALUE_WIDTH-1:0] value
);
  import bsl_pkg::*;

  logic                   in_list;
  logic                   at_tail;
  logic                   at_end;
  logic [VALUE_WIDTH-1:0] value_next;

  assign in_list = {1'b0, idx} < ctl.count;
  assign at_tail = {1'b0, idx} == ctl.count;
  assign at_end  = ({1'b0, idx} + CNT_W'(1)) == ctl.count;
  // first match anywhere at or before this cell
  assign hit_out = hit_in | (in_list && (value == ctl.value));

  always_comb begin
    value_next = value;
    unique case (ctl.cmd)
      CELL_HOLD:    value_next = value;
      CELL_APPEND:  if (at_tail) value_next = ctl.value;
      CELL_INSERT:  value_next = (idx == '0) ? ctl.value : left_value;
      CELL_DEL_VAL: if (hit_out) value_next = right_value;
      CELL_DEL_POS: if ((8'(idx) + 8'd1) >= ctl.position) value_next = right_value;
      CELL_REVERSE: value_next = mirror_value;
      CELL_ROTATE:  value_next = at_end ? head_value : right_value;
      default:      value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

@@ src/bounded_sequence_list_engine.sv @@
// Top level of the bounded sequence list engine: controller, count and the
// chain of list cells. Depends on bsl_pkg and bsl_cell.
//
// An edit (append, insert, delete by value or position, reverse) never raises
// busy: start is accepted whenever busy is low, and its single result
// strobes in the cycle after acceptance, so edits can be issued every cycle.
// A readout of n entries keeps busy high while the cell ring rotates one
// place per cycle; its n results strobe on consecutive cycles, each one
// registered from the head cell during the read state, the final one with
// last set, and a new start is taken in that final cycle. A readout of an
// empty list gives one result, status empty, in the next cycle. Results are
// shown for exactly one cycle and cannot be held off.
module bounded_sequence_list_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  bsl_pkg::in_item_t  item,
  output logic               strobe,
  output bsl_pkg::out_item_t result
);
  import bsl_pkg::*;

  state_t                 state, state_next;
  logic [CNT_W-1:0]       count, count_next;
  logic [IDX_W-1:0]       rd_idx, rd_idx_next;
  logic                   strobe_next;
  out_item_t              result_next;
  cell_ctl_t              ctl;
  logic                   accept;
  logic                   rd_last;
  logic                   room;
  logic                   pos_ok;
  logic                   found;

  logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
  logic [VALUE_WIDTH-1:0] mirror     [DEPTH];
  logic [DEPTH:0]         hit;

  assign accept  = start && !busy;
  assign room    = count < CNT_W'(DEPTH);
  assign pos_ok  = (item.position != 8'd0) && (item.position <= 8'(count));
  assign rd_last = ({1'b0, rd_idx} + CNT_W'(1)) == count;
  assign found   = hit[DEPTH];
  assign hit[0]  = 1'b0;

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign mirror[i] = cell_value[IDX_W'(count - CNT_W'(i) - CNT_W'(1))];
    bsl_cell u_cell (
      .clk          (clk),
      .idx          (IDX_W'(i)),
      .ctl          (ctl),
      .left_value   (cell_value[(i == 0) ? 0 : i - 1]),
      .right_value  (cell_value[(i == DEPTH - 1) ? i : i + 1]),
      .head_value   (cell_value[0]),
      .mirror_value (mirror[i]),
      .hit_in       (hit[i]),
      .hit_out      (hit[i+1]),
      .value        (cell_value[i])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (op_t'(item.operation) == OP_READOUT) && (count != '0)) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (rd_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    busy = (state == ST_READ);
  end

  // datapath control and result formation
  always_comb begin
    ctl.cmd               = CELL_HOLD;
    ctl.count             = count;
    ctl.value             = VALUE_WIDTH'(item.item_value);
    ctl.position          = item.position;
    count_next            = count;
    rd_idx_next           = rd_idx;
    strobe_next           = 1'b0;
    result_next.out_value = '0;
    result_next.status    = STAT_OK;
    result_next.last      = 1'b1;

    if (state == ST_READ) begin
      ctl.cmd               = CELL_ROTATE;
      strobe_next           = 1'b1;
      result_next.out_value = 32'(signed'(cell_value[0]));
      result_next.last      = rd_last;
      rd_idx_next           = rd_idx + IDX_W'(1);
    end else if (accept) begin
      strobe_next = 1'b1;
      rd_idx_next = '0;
      unique case (item.operation)
        OP_APPEND, OP_INSERT: begin
          if (room) begin
            ctl.cmd    = (op_t'(item.operation) == OP_APPEND) ? CELL_APPEND : CELL_INSERT;
            count_next = count + CNT_W'(1);
          end else begin
            result_next.status = STAT_FULL;
          end
        end
        OP_DEL_VAL: begin
          ctl.cmd = CELL_DEL_VAL;
          if (found) begin
            count_next = count - CNT_W'(1);
          end else begin
            result_next.status = STAT_NOT_FOUND;
          end
        end
        OP_DEL_POS: begin
          if (pos_ok) begin
            ctl.cmd    = CELL_DEL_POS;
            count_next = count - CNT_W'(1);
          end else begin
            result_next.status = STAT_NOT_FOUND;
          end
        end
        OP_REVERSE: ctl.cmd = CELL_REVERSE;
        OP_READOUT: begin
          if (count == '0) begin
            result_next.status = STAT_EMPTY;
          end else begin
            strobe_next = 1'b0;
          end
        end
        default: ;
      endcase
    end
    result_next.entry_count = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      rd_idx <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      rd_idx <= rd_idx_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule
